### hw/rtl/msort_pkg.sv
// Shared types and constants for the merge sort engine.
// No dependencies; imported by msort_cmp, merge_sort_engine_core and msort_chk.
package msort_pkg;

  localparam int CAPACITY   = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);
  localparam int SUM_W      = CNT_W + 1;

  typedef logic [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value_in;
    logic                         last_in;
  } in_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value_out;
    logic                         last_out;
    logic                         overflow;
  } out_req_t;

  // which run heads still hold unread elements
  typedef struct packed {
    logic a_live;
    logic b_live;
  } heads_t;

endpackage

### hw/rtl/msort_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module msort_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### hw/rtl/msort_cmp.sv
// Shared compare/select unit: picks the next element of a two-run merge.
// Depends on msort_pkg.
module msort_cmp
  import msort_pkg::*;
(
  input  word_t  head_a,
  input  word_t  head_b,
  input  heads_t heads,
  output logic   take_a,
  output word_t  pick
);

  logic a_le_b;

  // ties go to run A, which was loaded earlier: keeps the sort stable
  assign a_le_b = $signed(head_a) <= $signed(head_b);
  assign take_a = heads.a_live && (!heads.b_live || a_le_b);
  assign pick   = take_a ? head_a : head_b;

endmodule

### hw/rtl/merge_sort_engine_core.sv
// Merge sort engine top level: load sequencer, bottom-up merge passes, emitter.
// Depends on msort_pkg, msort_ram, msort_cmp.
//
//   channel | direction | payload    | handshake
//   in_     | request   | in_req_t   | in_valid / in_stall
//   out_    | result    | out_req_t  | out_valid / out_stall
//
// Load: requests are taken while loading. The request marked last starts the sort.
// Sort: passes of run width 1,2,4,... while width < n; each element takes a
//   RAM read (FETCH), then a compare and write through the one shared compare
//   unit (MERGE); each run is set up in RUN and each pass in PASS.
// Emit: each result takes a RAM read, an output load and a handover (held by out_stall).
// Reset clears the sequencer, the element count and flags only; the stores need no clearing.
// out_stall holds the output register; input is stalled outside the load phase.
module merge_sort_engine_core
  import msort_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_data
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PASS,
    ST_RUN,
    ST_FETCH,
    ST_MERGE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;   // stored elements, also n of the sort
  logic             dropped_r, dropped_nxt;
  logic             sel_r, sel_nxt;       // buffer that holds the current data
  logic [CNT_W-1:0] w_r, w_nxt;           // run width of the pass
  logic [CNT_W-1:0] lo_r, lo_nxt;
  logic [CNT_W-1:0] mid_r, mid_nxt;
  logic [CNT_W-1:0] hi_r, hi_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] k_r, k_nxt;
  out_req_t         out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;

  logic             in_acc;
  logic             store_ok;
  logic [SUM_W-1:0] sum_mid, sum_hi;

  // RAM hookup
  logic              we0, we1;
  logic [ADDR_W-1:0] waddr0, raddr_a, raddr_b;
  word_t             wdata0;
  word_t             rd0_a, rd0_b, rd1_a, rd1_b;
  word_t             head_a, head_b, pick;
  heads_t            heads;
  logic              take_a;

  assign in_stall  = (state_r != ST_LOAD);
  assign in_acc    = in_valid && !in_stall;
  assign store_ok  = (count_r < CNT_W'(CAPACITY));
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // run bounds, one bit wider so lo + 2w cannot wrap
  assign sum_mid = {1'b0, lo_r} + {1'b0, w_r};
  assign sum_hi  = {1'b0, lo_r} + {w_r, 1'b0};

  // both buffers share the read addresses; the emitter uses port A
  assign raddr_a = (state_r == ST_EMIT_RD) ? k_r[ADDR_W-1:0] : i_r[ADDR_W-1:0];
  assign raddr_b = j_r[ADDR_W-1:0];
  assign head_a  = sel_r ? rd1_a : rd0_a;
  assign head_b  = sel_r ? rd1_b : rd0_b;

  // buffer 0 takes the load and the merges of even-numbered passes (first pass is pass 1)
  assign we0    = (in_acc && store_ok) || (state_r == ST_MERGE && sel_r);
  assign waddr0 = (state_r == ST_LOAD) ? count_r[ADDR_W-1:0] : k_r[ADDR_W-1:0];
  assign wdata0 = (state_r == ST_LOAD) ? word_t'(in_data.value_in) : pick;
  assign we1    = (state_r == ST_MERGE) && !sel_r;

  assign heads.a_live = (i_r < mid_r);
  assign heads.b_live = (j_r < hi_r);

  msort_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_buf0 (
    .clk     (clk),
    .we      (we0),
    .waddr   (waddr0),
    .wdata   (wdata0),
    .raddr_a (raddr_a),
    .rdata_a (rd0_a),
    .raddr_b (raddr_b),
    .rdata_b (rd0_b)
  );

  msort_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_buf1 (
    .clk     (clk),
    .we      (we1),
    .waddr   (k_r[ADDR_W-1:0]),
    .wdata   (pick),
    .raddr_a (raddr_a),
    .rdata_a (rd1_a),
    .raddr_b (raddr_b),
    .rdata_b (rd1_b)
  );

  msort_cmp u_cmp (
    .head_a (head_a),
    .head_b (head_b),
    .heads  (heads),
    .take_a (take_a),
    .pick   (pick)
  );

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    sel_nxt       = sel_r;
    w_nxt         = w_r;
    lo_nxt        = lo_r;
    mid_nxt       = mid_r;
    hi_nxt        = hi_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    k_nxt         = k_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;

    unique case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (store_ok) begin
            count_nxt = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;   // full: drop, remember it for the run
          end
          if (in_data.last_in) begin
            w_nxt     = CNT_W'(1);
            state_nxt = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        if (w_r < count_r) begin
          lo_nxt    = '0;
          state_nxt = ST_RUN;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_RUN: begin
        if (lo_r < count_r) begin
          // a lone tail run merges with an empty partner, i.e. gets copied
          mid_nxt   = (sum_mid > {1'b0, count_r}) ? count_r : sum_mid[CNT_W-1:0];
          hi_nxt    = (sum_hi > {1'b0, count_r}) ? count_r : sum_hi[CNT_W-1:0];
          i_nxt     = lo_r;
          j_nxt     = (sum_mid > {1'b0, count_r}) ? count_r : sum_mid[CNT_W-1:0];
          k_nxt     = lo_r;
          state_nxt = ST_FETCH;
        end else begin
          w_nxt     = {w_r[CNT_W-2:0], 1'b0};
          sel_nxt   = !sel_r;
          state_nxt = ST_PASS;
        end
      end
      ST_FETCH: begin
        state_nxt = ST_MERGE;
      end
      ST_MERGE: begin
        if (take_a) begin
          i_nxt = i_r + CNT_W'(1);
        end else begin
          j_nxt = j_r + CNT_W'(1);
        end
        k_nxt = k_r + CNT_W'(1);
        if (k_r + CNT_W'(1) == hi_r) begin
          lo_nxt    = hi_r;
          state_nxt = ST_RUN;
        end else begin
          state_nxt = ST_FETCH;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_nxt.value_out = head_a;
        out_nxt.last_out  = (k_r + CNT_W'(1) == count_r);
        out_nxt.overflow  = dropped_r;
        out_valid_nxt     = 1'b1;
        state_nxt         = ST_EMIT_WAIT;
      end
      ST_EMIT_WAIT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          if (out_r.last_out) begin
            count_nxt   = '0;
            dropped_nxt = 1'b0;
            sel_nxt     = 1'b0;
            state_nxt   = ST_LOAD;
          end else begin
            k_nxt     = k_r + CNT_W'(1);
            state_nxt = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      dropped_r   <= 1'b0;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      dropped_r   <= dropped_nxt;
      sel_r       <= sel_nxt;
      out_valid_r <= out_valid_nxt;
    end
    w_r   <= w_nxt;
    lo_r  <= lo_nxt;
    mid_r <= mid_nxt;
    hi_r  <= hi_nxt;
    i_r   <= i_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
    out_r <= out_nxt;
  end

endmodule

### hw/rtl/msort_chk.sv
// Port-level checker for the merge sort engine, bound to the top level.
// Depends on msort_pkg and merge_sort_engine_core.
module msort_chk
  import msort_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_stall,
  input in_req_t  in_data,
  input logic     out_valid,
  input logic     out_stall,
  input out_req_t out_data
);

  // loading and emitting never overlap
  a_no_load_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  // the last element of a batch starts the sort, so input closes at once
  a_last_closes_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_data.last_in) |=> in_stall)
    else $error("input still open after last request");

  // a taken final result ends the run
  a_run_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && out_data.last_out) |=> !out_valid)
    else $error("result shown after end of run");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind merge_sort_engine_core msort_chk u_msort_chk (.*);
